// ----- src/ccpm_pkg.sv -----
// Package for the contrast curve pixel map: widths, constants and the
// payload types that travel down the divider chain.
// No dependencies.
`default_nettype none

package ccpm_pkg;

  // Width of one pixel channel.
  localparam int unsigned PixW = 8;
  // Number of channels that go through the curve (blue, green, red).
  localparam int unsigned NumLanes = 3;
  // One quotient bit per chain cell; the quotient always fits in a channel.
  localparam int unsigned DivSteps = PixW;
  // Full-scale channel value.
  localparam logic [PixW-1:0] FullScale = 8'd255;
  // Most negative contrast code, and the value it is clamped to.
  localparam logic [PixW-1:0] LevelMinCode = 8'h80;
  localparam logic [PixW-1:0] LevelClamp = 8'h81;

  // Per-channel working state of a division in flight.
  typedef struct packed {
    logic [PixW-1:0] rem;     // partial remainder, always below the divisor
    logic [PixW-1:0] bits;    // unused dividend bits, shifted out as quotient bits enter
    logic            sat;     // result is forced to a rail
    logic            sat_hi;  // rail is full scale when set, zero otherwise
  } ccpm_lane_t;

  // Everything one pixel carries from cell to cell.
  typedef struct packed {
    ccpm_lane_t [NumLanes-1:0] lane;
    logic [PixW-1:0]           den;    // shared divisor of the three channels
    logic [PixW-1:0]           off;    // offset added to the quotient
    logic [PixW-1:0]           alpha;  // passes untouched
  } ccpm_work_t;

endpackage

`default_nettype wire

// ----- src/ccpm_front.sv -----
// Front cell of the contrast curve: clamps the contrast level, picks the
// curve segment per channel and forms dividend, divisor and offset.
// Depends on ccpm_pkg.
`default_nettype none

module ccpm_front (
  input  wire logic                                           clk_i,
  input  wire logic                                           rst_ni,
  input  wire logic [ccpm_pkg::PixW-1:0]                      level_i,
  input  wire logic                                           valid_i,
  output logic                                                ready_o,
  input  wire logic [ccpm_pkg::NumLanes-1:0][ccpm_pkg::PixW-1:0] pix_i,
  input  wire logic [ccpm_pkg::PixW-1:0]                      alpha_i,
  output logic                                                valid_o,
  input  wire logic                                           ready_i,
  output ccpm_pkg::ccpm_work_t                                work_o
);

  logic                                valid_q;
  ccpm_pkg::ccpm_work_t                work_d, work_q;
  logic [ccpm_pkg::PixW-1:0]           level_c;
  logic                                pos;
  logic [ccpm_pkg::PixW-1:0]           mag;
  logic [ccpm_pkg::PixW-1:0]           hi_edge;
  logic [ccpm_pkg::PixW-1:0]           factor;
  logic [ccpm_pkg::NumLanes-1:0][ccpm_pkg::PixW-1:0]   mult_a;
  logic [ccpm_pkg::NumLanes-1:0][2*ccpm_pkg::PixW-1:0] prod;

  // Clamp the level and derive the values shared by all three channels.
  always_comb begin
    level_c = (level_i == ccpm_pkg::LevelMinCode) ? ccpm_pkg::LevelClamp : level_i;
    pos     = !level_c[ccpm_pkg::PixW-1] && (level_c != '0);
    mag     = ccpm_pkg::PixW'(0) - level_c;
    hi_edge = ccpm_pkg::FullScale - level_c;
    // Flattening (and identity): v * (255 + 2c) / 255 - c.
    // Steepening: 255 * (v - c) / (255 - 2c).
    if (pos) begin
      factor = ccpm_pkg::FullScale;
    end else begin
      factor = ccpm_pkg::FullScale - {mag[ccpm_pkg::PixW-2:0], 1'b0};
    end
  end

  // Per-channel segment choice and dividend product.
  always_comb begin
    work_d       = work_q;
    work_d.alpha = alpha_i;
    if (pos) begin
      work_d.den = ccpm_pkg::FullScale - {level_c[ccpm_pkg::PixW-2:0], 1'b0};
      work_d.off = '0;
    end else begin
      work_d.den = ccpm_pkg::FullScale;
      work_d.off = mag;
    end
    for (int i = 0; i < ccpm_pkg::NumLanes; i++) begin
      mult_a[i] = pos ? (pix_i[i] - level_c) : pix_i[i];
      prod[i]   = (2*ccpm_pkg::PixW)'(mult_a[i]) * (2*ccpm_pkg::PixW)'(factor);
      work_d.lane[i].rem    = prod[i][2*ccpm_pkg::PixW-1:ccpm_pkg::PixW];
      work_d.lane[i].bits   = prod[i][ccpm_pkg::PixW-1:0];
      work_d.lane[i].sat    = 1'b0;
      work_d.lane[i].sat_hi = 1'b0;
      if (pos && (pix_i[i] < level_c)) begin
        work_d.lane[i].sat  = 1'b1;
        work_d.lane[i].rem  = '0;
        work_d.lane[i].bits = '0;
      end else if (pos && (pix_i[i] >= hi_edge)) begin
        work_d.lane[i].sat    = 1'b1;
        work_d.lane[i].sat_hi = 1'b1;
        work_d.lane[i].rem    = '0;
        work_d.lane[i].bits   = '0;
      end
    end
  end

  // The stage takes a new pixel whenever it is empty or its content moves on.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

`default_nettype wire

// ----- src/ccpm_div_cell.sv -----
// One cell of the restoring divider chain: produces one quotient bit for
// each channel and hands the pixel to the next cell.
// Depends on ccpm_pkg.
`default_nettype none

module ccpm_div_cell (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      ready_o,
  input  wire ccpm_pkg::ccpm_work_t work_i,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output ccpm_pkg::ccpm_work_t      work_o
);

  logic                                                valid_q;
  ccpm_pkg::ccpm_work_t                                work_d, work_q;
  logic [ccpm_pkg::NumLanes-1:0][ccpm_pkg::PixW:0]     trial;
  logic [ccpm_pkg::NumLanes-1:0][ccpm_pkg::PixW:0]     diff;
  logic [ccpm_pkg::NumLanes-1:0]                       fits;

  // Shift in the next dividend bit and subtract the divisor where it fits.
  // The remainder stays below the divisor, so the difference fits a channel.
  always_comb begin
    work_d = work_i;
    for (int i = 0; i < ccpm_pkg::NumLanes; i++) begin
      trial[i] = {work_i.lane[i].rem, work_i.lane[i].bits[ccpm_pkg::PixW-1]};
      diff[i]  = trial[i] - {1'b0, work_i.den};
      fits[i]  = trial[i] >= {1'b0, work_i.den};
      work_d.lane[i].rem  = fits[i] ? diff[i][ccpm_pkg::PixW-1:0]
                                    : trial[i][ccpm_pkg::PixW-1:0];
      work_d.lane[i].bits = {work_i.lane[i].bits[ccpm_pkg::PixW-2:0], fits[i]};
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

`default_nettype wire

// ----- src/contrast_curve_pixel_map.sv -----
// Top level of the contrast curve pixel map: contrast register, front cell,
// divider chain and output register.
// Depends on ccpm_pkg, ccpm_front and ccpm_div_cell.
//
//   channel   signals                          direction  notes
//   -------   -------------------------------  ---------  -------------------------
//   pixel in  in_valid_i / in_ready_o, *_in_i  input      blue, green, red, alpha
//   pixel out out_valid_o / out_ready_i, *_out_o output   mapped channels, alpha
//   config    cfg_we_i, cfg_wdata_i            input      signed contrast level
//
// One pixel transaction is accepted per clock unless a stall has filled the chain.
// A pixel passes ten registers: the front cell, eight divider cells (one quotient
// bit each) and the output register.
// Every stage holds one pixel and loads whenever it is empty or drained, so a
// stall at the output fills the bubbles in the chain before input stops.
// Reset clears all valid flags and sets the contrast level to zero (identity).
`default_nettype none

module contrast_curve_pixel_map (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] blue_in_i,
  input  wire logic [7:0] green_in_i,
  input  wire logic [7:0] red_in_i,
  input  wire logic [7:0] alpha_in_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      blue_out_o,
  output logic [7:0]      green_out_o,
  output logic [7:0]      red_out_o,
  output logic [7:0]      alpha_out_o
);

  logic [ccpm_pkg::PixW-1:0]                         level_q;
  logic [ccpm_pkg::NumLanes-1:0][ccpm_pkg::PixW-1:0] pix_in;
  ccpm_pkg::ccpm_work_t                              work_s  [ccpm_pkg::DivSteps+1];
  logic                                              valid_s [ccpm_pkg::DivSteps+1];
  logic                                              ready_s [ccpm_pkg::DivSteps+1];
  logic                                              out_valid_q;
  logic [ccpm_pkg::NumLanes-1:0][ccpm_pkg::PixW-1:0] chan_d, chan_q;
  logic [ccpm_pkg::PixW-1:0]                         alpha_q;

  // Contrast register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else if (cfg_we_i) begin
      level_q <= cfg_wdata_i;
    end
  end

  assign pix_in = {red_in_i, green_in_i, blue_in_i};

  // Front cell: segment choice and dividend product.
  ccpm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .level_i (level_q),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .pix_i   (pix_in),
    .alpha_i (alpha_in_i),
    .valid_o (valid_s[0]),
    .ready_i (ready_s[0]),
    .work_o  (work_s[0])
  );

  // Divider chain, one quotient bit per cell.
  for (genvar k = 0; k < ccpm_pkg::DivSteps; k++) begin : g_cell
    ccpm_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[k]),
      .ready_o (ready_s[k]),
      .work_i  (work_s[k]),
      .valid_o (valid_s[k+1]),
      .ready_i (ready_s[k+1]),
      .work_o  (work_s[k+1])
    );
  end

  // Final value: a rail, or the quotient plus the flattening offset.
  always_comb begin
    for (int i = 0; i < ccpm_pkg::NumLanes; i++) begin
      if (work_s[ccpm_pkg::DivSteps].lane[i].sat) begin
        chan_d[i] = {ccpm_pkg::PixW{work_s[ccpm_pkg::DivSteps].lane[i].sat_hi}};
      end else begin
        chan_d[i] = work_s[ccpm_pkg::DivSteps].lane[i].bits
                  + work_s[ccpm_pkg::DivSteps].off;
      end
    end
  end

  // Output register.
  assign ready_s[ccpm_pkg::DivSteps] = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_s[ccpm_pkg::DivSteps]) begin
      out_valid_q <= valid_s[ccpm_pkg::DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_s[ccpm_pkg::DivSteps] && ready_s[ccpm_pkg::DivSteps]) begin
      chan_q  <= chan_d;
      alpha_q <= work_s[ccpm_pkg::DivSteps].alpha;
    end
  end

  assign out_valid_o = out_valid_q;
  assign blue_out_o  = chan_q[0];
  assign green_out_o = chan_q[1];
  assign red_out_o   = chan_q[2];
  assign alpha_out_o = alpha_q;

endmodule

`default_nettype wire

// ----- src/ccpm_checker.sv -----
// Port-level checks for the contrast curve pixel map, attached by bind.
// Depends on the ports of contrast_curve_pixel_map only.
`default_nettype none

module ccpm_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] blue_out_o,
  input wire logic [7:0] green_out_o,
  input wire logic [7:0] red_out_o,
  input wire logic [7:0] alpha_out_o
);

  // A pending output transaction stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped before the transaction completed");

  // A stalled output transaction keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(blue_out_o) && $stable(green_out_o)
                                    && $stable(red_out_o) && $stable(alpha_out_o))
    else $error("output payload changed during a stall");

  // With the output register empty the whole chain drains, so input is open.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked while the output register is empty");

  // Nothing can reach the output in the first cycle after reset.
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind contrast_curve_pixel_map ccpm_checker u_ccpm_checker (.*);

`default_nettype wire
